// ===== hw/rtl/qfc_pkg.sv =====
// Shared constants, payload types and helper functions for the quadtree culler.
package qfc_pkg;

	localparam int MAX_LEVELS = 5;
	localparam int MAX_PLANES = 6;
	localparam int NODE_CAP   = ((1 << (2 * MAX_LEVELS)) - 1) / 3;
	localparam int NODE_W     = $clog2(NODE_CAP);
	localparam int SP_W       = $clog2(MAX_LEVELS + 1);
	localparam int STK_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PL_W       = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int ADDR_W     = 5;

	// request modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_CULL  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_QUERY = 2'd3;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_MIN_X   = 3'd0;
	localparam logic [2:0] REG_MIN_Z   = 3'd1;
	localparam logic [2:0] REG_MAX_X   = 3'd2;
	localparam logic [2:0] REG_MAX_Z   = 3'd3;
	localparam logic [2:0] REG_FLOOR   = 3'd4;
	localparam logic [2:0] REG_CEILING = 3'd5;
	localparam logic [2:0] REG_LEVELS  = 3'd6;

	// children per node
	localparam logic [2:0] CHILDREN = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         plane_slot;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] plane_offset;
		logic [2:0]         plane_count;
		logic [8:0]         node_number;
	} req_t;

	typedef struct packed {
		logic       node_visible;
		logic [8:0] visible_total;
	} res_t;

	typedef struct packed {
		logic signed [31:0] region_min_x;
		logic signed [31:0] region_min_z;
		logic signed [31:0] region_max_x;
		logic signed [31:0] region_max_z;
		logic signed [31:0] floor_height;
		logic signed [31:0] ceiling_height;
		logic [2:0]         levels_in_use;
	} cfg_t;

	typedef enum logic [2:0] {
		RAM_IDLE,
		RAM_CLEAR,
		RAM_MARK,
		RAM_COUNT,
		RAM_QUERY
	} ram_op_t;

	typedef struct packed {
		logic            take;
		logic            issue;
		logic [PL_W-1:0] plane_sel;
		logic            push;
		logic            pop;
		logic            child;
		logic            sweep_step;
		logic            emit;
		ram_op_t         ram_op;
	} cmd_t;

	typedef struct packed {
		logic [2:0] np;
		logic       pipe_busy;
		logic       culled;
		logic       can_push;
		logic       sp_zero;
		logic       top_full;
		logic       lv_zero;
		logic       cnt_last;
		logic       all_last;
	} sts_t;

	// levels above the built depth act as the built depth
	function automatic logic [2:0] eff_levels(input logic [2:0] lv);
		return (int'(lv) > MAX_LEVELS) ? 3'(MAX_LEVELS) : lv;
	endfunction

	// number of nodes in a full tree of lv levels
	function automatic logic [NODE_W-1:0] present_nodes(input logic [2:0] lv);
		int n;
		int p;
		n = 0;
		p = 1;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			if (k < int'(lv)) n = n + p;
			p = p * 4;
		end
		return NODE_W'(n);
	endfunction

	// floor((a + b) / 2) without overflow
	function automatic logic signed [31:0] midpoint(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		return s[32:1];
	endfunction

	function automatic logic signed [63:0] min64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

// ===== hw/rtl/qfc_ram.sv =====
// Generic single-port RAM with registered read.
module qfc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/qfc_regs.sv =====
// APB configuration registers of the quadtree culler.
module qfc_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [qfc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output qfc_pkg::cfg_t             cfg
);

	qfc_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_min_x   <= 32'sd0;
			cfg_q.region_min_z   <= 32'sd0;
			cfg_q.region_max_x   <= 32'sd65536;
			cfg_q.region_max_z   <= 32'sd65536;
			cfg_q.floor_height   <= 32'sd0;
			cfg_q.ceiling_height <= 32'sd65536;
			cfg_q.levels_in_use  <= 3'd5;
		end else if (wr) begin
			case (idx)
				qfc_pkg::REG_MIN_X:   cfg_q.region_min_x   <= pwdata;
				qfc_pkg::REG_MIN_Z:   cfg_q.region_min_z   <= pwdata;
				qfc_pkg::REG_MAX_X:   cfg_q.region_max_x   <= pwdata;
				qfc_pkg::REG_MAX_Z:   cfg_q.region_max_z   <= pwdata;
				qfc_pkg::REG_FLOOR:   cfg_q.floor_height   <= pwdata;
				qfc_pkg::REG_CEILING: cfg_q.ceiling_height <= pwdata;
				qfc_pkg::REG_LEVELS:  cfg_q.levels_in_use  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// readback
	always_comb begin
		case (idx)
			qfc_pkg::REG_MIN_X:   prdata = cfg_q.region_min_x;
			qfc_pkg::REG_MIN_Z:   prdata = cfg_q.region_min_z;
			qfc_pkg::REG_MAX_X:   prdata = cfg_q.region_max_x;
			qfc_pkg::REG_MAX_Z:   prdata = cfg_q.region_max_z;
			qfc_pkg::REG_FLOOR:   prdata = cfg_q.floor_height;
			qfc_pkg::REG_CEILING: prdata = cfg_q.ceiling_height;
			qfc_pkg::REG_LEVELS:  prdata = {29'd0, cfg_q.levels_in_use};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

// ===== hw/rtl/qfc_ctrl.sv =====
// Sequencer of the quadtree culler: walks the tree and drives the datapath.
module qfc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    mode,
	input  qfc_pkg::sts_t sts,
	output qfc_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLR,
		S_QRD,
		S_TEST,
		S_DEC,
		S_ADV,
		S_CNT,
		S_CNTW,
		S_FIN
	} state_t;

	state_t                   state_q;
	logic [2:0]               pcnt_q;
	logic                     done_q;
	logic                     more_planes;

	assign more_planes = pcnt_q < sts.np;
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;

	// commands per state
	always_comb begin
		cmd = '0;
		cmd.ram_op = qfc_pkg::RAM_IDLE;
		case (state_q)
			S_IDLE: cmd.take = start;
			S_INIT, S_CLR: begin
				cmd.ram_op     = qfc_pkg::RAM_CLEAR;
				cmd.sweep_step = 1'b1;
			end
			S_QRD: cmd.ram_op = qfc_pkg::RAM_QUERY;
			S_TEST: begin
				cmd.issue     = more_planes;
				cmd.plane_sel = qfc_pkg::PL_W'(pcnt_q);
			end
			S_DEC: begin
				if (!sts.culled) begin
					cmd.ram_op = qfc_pkg::RAM_MARK;
					cmd.push   = sts.can_push;
				end
			end
			S_ADV: begin
				if (!sts.sp_zero) begin
					cmd.pop   = sts.top_full;
					cmd.child = !sts.top_full;
				end
			end
			S_CNT: begin
				cmd.ram_op     = qfc_pkg::RAM_COUNT;
				cmd.sweep_step = 1'b1;
			end
			S_FIN: cmd.emit = 1'b1;
			default: ;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			pcnt_q  <= 3'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			case (state_q)
				S_INIT: if (sts.all_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						pcnt_q <= 3'd0;
						case (mode)
							qfc_pkg::MODE_LOAD:  state_q <= S_FIN;
							qfc_pkg::MODE_CULL:  state_q <= sts.lv_zero ? S_FIN : S_TEST;
							qfc_pkg::MODE_CLEAR: state_q <= S_CLR;
							default:             state_q <= S_QRD;
						endcase
					end
				end
				S_CLR: if (sts.all_last) state_q <= S_FIN;
				S_QRD: state_q <= S_FIN;
				S_TEST: begin
					if (more_planes) pcnt_q <= pcnt_q + 3'd1;
					else if (!sts.pipe_busy) state_q <= S_DEC;
				end
				S_DEC: state_q <= S_ADV;
				S_ADV: begin
					if (sts.sp_zero) begin
						state_q <= S_CNT;
					end else if (!sts.top_full) begin
						pcnt_q  <= 3'd0;
						state_q <= S_TEST;
					end
				end
				S_CNT:  if (sts.cnt_last) state_q <= S_CNTW;
				S_CNTW: state_q <= S_FIN;
				S_FIN:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/qfc_dp.sv =====
// Datapath of the quadtree culler: plane store, node stack, plane test, bit memory.
module qfc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  qfc_pkg::cfg_t cfg,
	input  qfc_pkg::req_t req,
	input  qfc_pkg::cmd_t cmd,
	output qfc_pkg::sts_t sts,
	output qfc_pkg::res_t res
);

	localparam int NW = qfc_pkg::NODE_W;
	localparam int ML = qfc_pkg::MAX_LEVELS;
	localparam int MP = qfc_pkg::MAX_PLANES;

	qfc_pkg::req_t req_q;
	logic [2:0]    np_q;

	// plane store
	logic signed [31:0] pa_q [MP];
	logic signed [31:0] pb_q [MP];
	logic signed [31:0] pc_q [MP];
	logic signed [31:0] pd_q [MP];

	// current node
	logic signed [31:0] cx0_q, cz0_q, cx1_q, cz1_q;
	logic [NW-1:0]      idx_q;

	// ancestor stack
	logic signed [31:0]      sx0_q [ML];
	logic signed [31:0]      sz0_q [ML];
	logic signed [31:0]      sx1_q [ML];
	logic signed [31:0]      sz1_q [ML];
	logic [NW-1:0]           sidx_q [ML];
	logic [2:0]              sch_q [ML];
	logic [qfc_pkg::SP_W-1:0] sp_q;

	// plane test pipeline
	logic                v_s1, v_s2;
	logic signed [63:0]  ax0_s1, ax1_s1, cz0_s1, cz1_s1, bf_s1, bc_s1;
	logic signed [31:0]  d_s1;
	logic                above_s2;
	logic                cull_q;
	logic signed [65:0]  dist_min;

	// sweep and count
	logic [NW-1:0] sweep_q;
	logic          rd_cnt_q;
	logic [8:0]    total_q;
	qfc_pkg::res_t res_q;

	// bit memory port
	logic          ram_we;
	logic [NW-1:0] ram_addr;
	logic          ram_wdata;
	logic          ram_rdata;

	logic [2:0]                eff_lv;
	logic [NW-1:0]             present;
	logic [qfc_pkg::STK_W-1:0] top;
	logic [qfc_pkg::STK_W-1:0] push_at;
	logic signed [31:0]        mx, mz;
	logic [1:0]                ch;
	logic [NW+1:0]             nidx;
	logic                      node_ok;

	assign eff_lv  = qfc_pkg::eff_levels(cfg.levels_in_use);
	assign present = qfc_pkg::present_nodes(eff_lv);
	assign top     = qfc_pkg::STK_W'(sp_q - qfc_pkg::SP_W'(1));
	assign push_at = qfc_pkg::STK_W'(sp_q);
	assign mx      = qfc_pkg::midpoint(sx0_q[top], sx1_q[top]);
	assign mz      = qfc_pkg::midpoint(sz0_q[top], sz1_q[top]);
	assign ch      = sch_q[top][1:0];
	assign nidx    = {sidx_q[top], 2'b00} + (NW+2)'(ch) + (NW+2)'(1);
	assign node_ok = ({2'b00, req_q.node_number} < (NW+2)'(present))
		&& (req_q.node_number < 9'(qfc_pkg::NODE_CAP));

	// status to the sequencer
	always_comb begin
		sts.np        = np_q;
		sts.pipe_busy = v_s1 | v_s2;
		sts.culled    = cull_q;
		sts.can_push  = ({1'b0, sp_q} + (qfc_pkg::SP_W+1)'(1)) < (qfc_pkg::SP_W+1)'(eff_lv);
		sts.sp_zero   = (sp_q == '0);
		sts.top_full  = (sch_q[top] == qfc_pkg::CHILDREN);
		sts.lv_zero   = (eff_lv == 3'd0);
		sts.cnt_last  = (sweep_q == present - NW'(1));
		sts.all_last  = (sweep_q == NW'(qfc_pkg::NODE_CAP - 1));
	end

	// request capture and plane store write
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= req;
			np_q  <= (int'(req.plane_count) > MP) ? 3'(MP) : req.plane_count;
		end
		if (cmd.emit && req_q.mode == qfc_pkg::MODE_LOAD
				&& int'(req_q.plane_slot) < MP) begin
			pa_q[qfc_pkg::PL_W'(req_q.plane_slot)] <= req_q.normal_x;
			pb_q[qfc_pkg::PL_W'(req_q.plane_slot)] <= req_q.normal_y;
			pc_q[qfc_pkg::PL_W'(req_q.plane_slot)] <= req_q.normal_z;
			pd_q[qfc_pkg::PL_W'(req_q.plane_slot)] <= req_q.plane_offset;
		end
	end

	// current node and ancestor stack
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cx0_q <= cfg.region_min_x;
			cz0_q <= cfg.region_min_z;
			cx1_q <= cfg.region_max_x;
			cz1_q <= cfg.region_max_z;
			idx_q <= '0;
		end else if (cmd.child) begin
			cx0_q <= ch[1] ? mx : sx0_q[top];
			cx1_q <= ch[1] ? sx1_q[top] : mx;
			cz0_q <= ch[0] ? mz : sz0_q[top];
			cz1_q <= ch[0] ? sz1_q[top] : mz;
			idx_q <= nidx[NW-1:0];
		end
		if (cmd.push) begin
			sx0_q[push_at]  <= cx0_q;
			sz0_q[push_at]  <= cz0_q;
			sx1_q[push_at]  <= cx1_q;
			sz1_q[push_at]  <= cz1_q;
			sidx_q[push_at] <= idx_q;
		end
	end

	// stack control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			for (int i = 0; i < ML; i++) sch_q[i] <= 3'd0;
		end else begin
			if (cmd.take) begin
				sp_q <= '0;
			end else if (cmd.push) begin
				sp_q           <= sp_q + qfc_pkg::SP_W'(1);
				sch_q[push_at] <= 3'd0;
			end else if (cmd.pop) begin
				sp_q <= sp_q - qfc_pkg::SP_W'(1);
			end else if (cmd.child) begin
				sch_q[top] <= sch_q[top] + 3'd1;
			end
		end
	end

	// stage 1: six corner products of one plane
	always_ff @(posedge clk) begin
		ax0_s1 <= pa_q[cmd.plane_sel] * cx0_q;
		ax1_s1 <= pa_q[cmd.plane_sel] * cx1_q;
		cz0_s1 <= pc_q[cmd.plane_sel] * cz0_q;
		cz1_s1 <= pc_q[cmd.plane_sel] * cz1_q;
		bf_s1  <= pb_q[cmd.plane_sel] * cfg.floor_height;
		bc_s1  <= pb_q[cmd.plane_sel] * cfg.ceiling_height;
		d_s1   <= pd_q[cmd.plane_sel];
	end

	// stage 2: the lowest corner distance is the sum of per-axis minima
	always_comb begin
		dist_min = 66'(qfc_pkg::min64(ax0_s1, ax1_s1))
			+ 66'(qfc_pkg::min64(cz0_s1, cz1_s1))
			+ 66'(qfc_pkg::min64(bf_s1, bc_s1))
			+ (66'(d_s1) <<< 16);
	end

	always_ff @(posedge clk) begin
		above_s2 <= (dist_min > 66'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			cull_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.take || cmd.child) cull_q <= 1'b0;
			else if (v_s2 && above_s2) cull_q <= 1'b1;
		end
	end

	// bit memory port select
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = 1'b0;
		ram_addr  = sweep_q;
		case (cmd.ram_op)
			qfc_pkg::RAM_CLEAR: ram_we = 1'b1;
			qfc_pkg::RAM_MARK: begin
				ram_we    = 1'b1;
				ram_wdata = 1'b1;
				ram_addr  = idx_q;
			end
			qfc_pkg::RAM_QUERY: ram_addr = node_ok ? NW'(req_q.node_number) : '0;
			default: ;
		endcase
	end

	qfc_ram #(
		.WIDTH(1),
		.DEPTH(qfc_pkg::NODE_CAP)
	) u_bits (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// sweep address and visible count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q  <= '0;
			rd_cnt_q <= 1'b0;
			total_q  <= 9'd0;
		end else begin
			if (cmd.take) sweep_q <= '0;
			else if (cmd.sweep_step) sweep_q <= sweep_q + NW'(1);
			rd_cnt_q <= (cmd.ram_op == qfc_pkg::RAM_COUNT);
			if (cmd.take) total_q <= 9'd0;
			else if (rd_cnt_q && ram_rdata) total_q <= total_q + 9'd1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q.node_visible  <= (req_q.mode == qfc_pkg::MODE_QUERY) && node_ok && ram_rdata;
			res_q.visible_total <= (req_q.mode == qfc_pkg::MODE_CULL) ? total_q : 9'd0;
		end
	end

	assign res = res_q;

endmodule

// ===== hw/rtl/quadtree_frustum_cull.sv =====
// Top level of the quadtree frustum culler.
// Usage:
//   Requests enter on req when start is high and busy is low. Each request
//   yields one result on res, marked by done for exactly one cycle; the
//   receiver must take it then.
//   Configuration goes through the APB port (registers at 4*index); write it
//   only while busy is low and no result is pending.
// Sequence per request, from accept to done:
//   load plane writes its slot, query reads the node's bit, clear zeroes all
//   visibility bits (one bit per cycle). cull: for each visited node one plane
//   enters the two-stage multiply/sum pipeline per cycle, then the node is
//   marked unless culled and the walk descends or pops the stack; a count
//   sweep over each present node (up to 341) follows.
//   One request at a time: the tree walk shares one plane test unit and the
//   single port of the visibility bit memory.
// Reset: arst_n clears control; afterwards a clearing pass zeroes all 341
//   visibility bits with busy high. Plane slots hold no defined value until
//   loaded.
module quadtree_frustum_cull (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  qfc_pkg::req_t              req,
	output logic                       done,
	output qfc_pkg::res_t              res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [qfc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	qfc_pkg::cfg_t cfg;
	qfc_pkg::cmd_t cmd;
	qfc_pkg::sts_t sts;

	qfc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	qfc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (req.mode),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	qfc_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.res   (res)
	);

endmodule

// ===== verif/tb_quadtree_frustum_cull.sv =====
// Self-checking testbench for the quadtree frustum culler: directed table plus random requests.
module tb_quadtree_frustum_cull;

	localparam int WATCHDOG = 60000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	qfc_pkg::req_t req;
	logic done;
	qfc_pkg::res_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [qfc_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	quadtree_frustum_cull DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic signed [31:0] rgn_min_x, rgn_min_z, rgn_max_x, rgn_max_z;
	logic signed [31:0] box_floor, box_ceiling;
	logic [2:0] tree_levels;
	logic vis_map [qfc_pkg::NODE_CAP];
	logic signed [31:0] planes [qfc_pkg::MAX_PLANES][4];
	bit plane_loaded [qfc_pkg::MAX_PLANES];

	qfc_pkg::res_t expected_results[$];
	int mismatches;
	int idle_cycles;
	bit timed_out;

	// table of directed requests
	typedef struct {
		qfc_pkg::req_t r;
		bit has_fixed;
		qfc_pkg::res_t fixed;
	} step_t;
	step_t directed[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// exact sign test of a*x + b*y + c*z + d in Q32.32
	function automatic bit plane_above(int s, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic signed [127:0] acc;
		acc = 128'(planes[s][0]) * 128'(x) + 128'(planes[s][1]) * 128'(y)
			+ 128'(planes[s][2]) * 128'(z) + (128'(planes[s][3]) <<< 16);
		return acc > 0;
	endfunction

	function automatic bit box_culled(int np, logic signed [31:0] x0,
			logic signed [31:0] z0, logic signed [31:0] x1, logic signed [31:0] z1);
		bit all_pos;
		logic signed [31:0] x, y, z;
		for (int i = 0; i < np; i++) begin
			all_pos = 1;
			for (int c = 0; c < 8; c++) begin
				x = c[2] ? x1 : x0;
				z = c[1] ? z1 : z0;
				y = c[0] ? box_ceiling : box_floor;
				if (!plane_above(i, x, y, z)) all_pos = 0;
			end
			if (all_pos) return 1;
		end
		return 0;
	endfunction

	function automatic logic signed [31:0] half_way(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		return s[32:1];
	endfunction

	function automatic void walk_node(int idx, int depth, int lv, int np,
			logic signed [31:0] x0, logic signed [31:0] z0,
			logic signed [31:0] x1, logic signed [31:0] z1);
		logic signed [31:0] mx, mz;
		if (depth >= lv || idx >= qfc_pkg::NODE_CAP) return;
		if (box_culled(np, x0, z0, x1, z1)) return;
		vis_map[idx] = 1'b1;
		mx = half_way(x0, x1);
		mz = half_way(z0, z1);
		walk_node(4 * idx + 1, depth + 1, lv, np, x0, z0, mx, mz);
		walk_node(4 * idx + 2, depth + 1, lv, np, x0, mz, mx, z1);
		walk_node(4 * idx + 3, depth + 1, lv, np, mx, z0, x1, mz);
		walk_node(4 * idx + 4, depth + 1, lv, np, mx, mz, x1, z1);
	endfunction

	function automatic int live_levels();
		return (tree_levels > qfc_pkg::MAX_LEVELS) ? qfc_pkg::MAX_LEVELS
			: int'(tree_levels);
	endfunction

	function automatic int live_nodes();
		int n, p;
		n = 0;
		p = 1;
		for (int k = 0; k < live_levels(); k++) begin
			n += p;
			p *= 4;
		end
		return n;
	endfunction

	// compute the result of one request and update predictor state
	function automatic qfc_pkg::res_t predict_request(qfc_pkg::req_t r);
		qfc_pkg::res_t o;
		int np, cnt;
		o = '0;
		np = (r.plane_count > qfc_pkg::MAX_PLANES) ? qfc_pkg::MAX_PLANES
			: int'(r.plane_count);
		case (r.mode)
			qfc_pkg::MODE_LOAD: begin
				if (r.plane_slot < qfc_pkg::MAX_PLANES) begin
					planes[r.plane_slot][0] = r.normal_x;
					planes[r.plane_slot][1] = r.normal_y;
					planes[r.plane_slot][2] = r.normal_z;
					planes[r.plane_slot][3] = r.plane_offset;
					plane_loaded[r.plane_slot] = 1;
				end
			end
			qfc_pkg::MODE_CULL: begin
				walk_node(0, 0, live_levels(), np, rgn_min_x, rgn_min_z, rgn_max_x,
					rgn_max_z);
				cnt = 0;
				for (int i = 0; i < live_nodes(); i++) cnt += vis_map[i];
				o.visible_total = (cnt > 511) ? 9'd511 : 9'(cnt);
			end
			qfc_pkg::MODE_CLEAR: begin
				foreach (vis_map[i]) vis_map[i] = 1'b0;
			end
			default: begin
				if (r.node_number < live_nodes()) o.node_visible = vis_map[r.node_number];
			end
		endcase
		return o;
	endfunction

	// never cull with a slot that was not loaded
	function automatic int safe_count(int want);
		int n;
		n = 0;
		while (n < qfc_pkg::MAX_PLANES && plane_loaded[n]) n++;
		return (want > n) ? n : want;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= qfc_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			qfc_pkg::REG_MIN_X: rgn_min_x = val;
			qfc_pkg::REG_MIN_Z: rgn_min_z = val;
			qfc_pkg::REG_MAX_X: rgn_max_x = val;
			qfc_pkg::REG_MAX_Z: rgn_max_z = val;
			qfc_pkg::REG_FLOOR: box_floor = val;
			qfc_pkg::REG_CEILING: box_ceiling = val;
			default: tree_levels = val[2:0];
		endcase
	endtask

	task automatic set_region(logic signed [31:0] x0, logic signed [31:0] z0,
			logic signed [31:0] x1, logic signed [31:0] z1, logic signed [31:0] fl,
			logic signed [31:0] cl, logic [2:0] lv);
		write_reg(qfc_pkg::REG_MIN_X, x0);
		write_reg(qfc_pkg::REG_MIN_Z, z0);
		write_reg(qfc_pkg::REG_MAX_X, x1);
		write_reg(qfc_pkg::REG_MAX_Z, z1);
		write_reg(qfc_pkg::REG_FLOOR, fl);
		write_reg(qfc_pkg::REG_CEILING, cl);
		write_reg(qfc_pkg::REG_LEVELS, 32'(lv));
	endtask

	// issue one request, with a random gap first; start stays high across a zero gap
	task automatic send_request(qfc_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(predict_request(r));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", res);
			end else begin
				qfc_pkg::res_t e;
				e = expected_results.pop_front();
				if (res.node_visible !== e.node_visible
						|| res.visible_total !== e.visible_total) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected vis=%0d total=%0d got vis=%0d total=%0d",
							e.node_visible, e.visible_total, res.node_visible,
							res.visible_total);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("quadtree_frustum_cull verification failed");
			$finish;
		end
	end

	function automatic qfc_pkg::req_t mk(logic [1:0] m, logic [2:0] slot, logic [31:0] a,
			logic [31:0] b, logic [31:0] c, logic [31:0] d, logic [2:0] np,
			logic [8:0] node);
		qfc_pkg::req_t r;
		r.mode = m;
		r.plane_slot = slot;
		r.normal_x = a;
		r.normal_y = b;
		r.normal_z = c;
		r.plane_offset = d;
		r.plane_count = np;
		r.node_number = node;
		return r;
	endfunction

	function automatic void add_row(qfc_pkg::req_t r, bit fixed_known, qfc_pkg::res_t f);
		step_t s;
		s.r = r;
		s.has_fixed = fixed_known;
		s.fixed = f;
		directed.push_back(s);
	endfunction

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			2: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
		endcase
	endfunction

	initial begin
		qfc_pkg::res_t f;
		qfc_pkg::req_t r;
		int phase;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 0;
		rgn_min_x = 0; rgn_min_z = 0; rgn_max_x = 65536; rgn_max_z = 65536;
		box_floor = 0; box_ceiling = 65536; tree_levels = 5;
		foreach (vis_map[i]) vis_map[i] = 1'b0;
		foreach (plane_loaded[i]) plane_loaded[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: queries after reset, loads, culls, absent nodes, clear
		f = '0;
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd0), 1, f);
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd340), 1, f);
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd511), 1, f);
		f.visible_total = 9'd341;
		add_row(mk(qfc_pkg::MODE_CULL, 0, 0, 0, 0, 0, 0, 0), 1, f);
		f = '0;
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd340), 0, f);
		add_row(mk(qfc_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd5), 1, f);
		// plane x > 0.5 keeps the low half
		add_row(mk(qfc_pkg::MODE_LOAD, 0, 32'h0001_0000, 0, 0, 32'hffff_8000, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_LOAD, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_LOAD, 7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_LOAD, 2, 0, 32'hffff_0000, 0, 32'h0000_8000, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_LOAD, 3, 0, 0, 32'hffff_0000, 0, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_LOAD, 4, 0, 0, 0, 32'hffff_ffff, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_LOAD, 5, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 0, 0), 1, f);
		add_row(mk(qfc_pkg::MODE_CULL, 0, 0, 0, 0, 0, 3'd1, 0), 0, f);
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd1), 0, f);
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd4), 0, f);
		add_row(mk(qfc_pkg::MODE_CULL, 0, 0, 0, 0, 0, 3'd7, 0), 0, f);
		add_row(mk(qfc_pkg::MODE_CULL, 0, 0, 0, 0, 0, 3'd3, 0), 0, f);
		add_row(mk(qfc_pkg::MODE_QUERY, 0, 0, 0, 0, 0, 0, 9'd340), 0, f);
		add_row(mk(qfc_pkg::MODE_QUERY, 3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 3'd7, 9'd84), 0, f);

		foreach (directed[i]) begin
			send_request(directed[i].r);
			if (directed[i].has_fixed && expected_results[$] != directed[i].fixed) begin
				mismatches++;
				if (mismatches <= 10) $display("directed row %0d disagrees with table", i);
			end
		end
		wait_drained();

		// random phases over several region settings
		for (phase = 0; phase < 8 && !timed_out; phase++) begin
			case (phase)
				0: set_region(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
					32'h8000_0000, 32'h7fff_ffff, 3'd5);
				1: set_region(0, 0, 32'h0004_0000, 32'h0004_0000, 0, 32'h0001_0000, 3'd3);
				2: set_region(32'h0002_0000, 32'h0002_0000, 32'hfffe_0000, 32'hfffe_0000,
					32'h0001_0000, 0, 3'd1);
				3: set_region(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
					32'h7fff_ffff, 32'h8000_0000, 3'd0);
				4: set_region(32'hfffc_0000, 0, 32'h0004_0000, 32'h0002_0000,
					32'hffff_0000, 32'h0001_0000, 3'd7);
				5: set_region(0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 3'd2);
				default: set_region(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
					rand_q(), 3'($urandom_range(0, 7)));
			endcase
			repeat (52) begin
				r = mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand_q(),
					rand_q(), rand_q(), rand_q(), 3'($urandom_range(0, 7)),
					9'($urandom_range(0, 511)));
				if ($urandom_range(0, 4) == 0) r.mode = qfc_pkg::MODE_CLEAR;
				if (r.mode == qfc_pkg::MODE_QUERY && $urandom_range(0, 1))
					r.node_number = 9'($urandom_range(0, 340));
				if (r.mode == qfc_pkg::MODE_CULL) begin
					if (r.plane_count == 7 && safe_count(7) == qfc_pkg::MAX_PLANES)
						r.plane_count = 7;
					else r.plane_count = 3'(safe_count(int'(r.plane_count)));
				end
				send_request(r);
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_results.size() == 0)
			$display("quadtree_frustum_cull verification clean");
		else
			$display("quadtree_frustum_cull verification failed");
		$finish;
	end

endmodule
